// ----- rtl/core/sqb_pkg.sv -----
`default_nettype none

package sqb_pkg;

  localparam int unsigned MaxVertsDefault = 4096;
  localparam int unsigned CmdDepthDefault = 2;
  localparam int unsigned ResDepthDefault = 2;

  // CORDIC gain compensation in Q2.30.
  localparam logic signed [32:0] CordicK = 33'sd652032875;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  localparam logic CFG_ATLAS_W = 1'b0;
  localparam logic CFG_ATLAS_H = 1'b1;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FLUSH,
    BK_START,
    BK_CALC,
    BK_MUL,
    BK_COR_A,
    BK_COR_B
  } back_state_e;

  typedef struct packed {
    logic               flush;
    logic [15:0]        flush_tex;
    logic [12:0]        flush_cnt;
    logic               draw;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        size_w;
    logic [31:0]        size_h;
    logic [15:0]        angle;
    logic [31:0]        src_origin;
    logic [31:0]        src_extent;
    logic [31:0]        color;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] vert_x;
    logic [31:0] vert_y;
    logic [31:0] vert_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [31:0] vert_color;
    logic [15:0] batch_texture;
    logic [12:0] index_count;
    logic        last;
  } res_t;

  // Arctangent of 2^-i in binary angle units, 65536 to the turn.
  function automatic logic [13:0] atan_lut(input logic [3:0] i);
    logic [13:0] r;
    unique case (i)
      4'd0:    r = 14'd8192;
      4'd1:    r = 14'd4836;
      4'd2:    r = 14'd2555;
      4'd3:    r = 14'd1297;
      4'd4:    r = 14'd651;
      4'd5:    r = 14'd326;
      4'd6:    r = 14'd163;
      4'd7:    r = 14'd81;
      4'd8:    r = 14'd41;
      4'd9:    r = 14'd20;
      4'd10:   r = 14'd10;
      4'd11:   r = 14'd5;
      4'd12:   r = 14'd3;
      4'd13:   r = 14'd1;
      4'd14:   r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

  // Clamp a widened sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    logic [31:0] r;
    if ((v[37:31] == 7'h7f) || (v[37:31] == 7'h00)) begin
      r = v[31:0];
    end else if (v[37]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sprite_quad_batcher.sv -----
`default_nettype none

// Channel   Direction  Handshake            Word
// draw      in         push / full          one draw or end item
// result    out        empty / pop          one vertex or flush record
// config    in         cfg_we_i, no wait    atlas width (0) or height (1)
//
// In the back end a draw item passes through a flush record when one is due, the
// 16-step CORDIC and the four 17-step texture coordinate dividers, which run side by side,
// a multiply state, then the BK_COR_A and BK_COR_B states for each corner.
// An end item reaches the back end only when it closes a batch, as a flush record.
// The front end keeps the batch state and classifies items at once, so up to CMD_DEPTH
// items (two by default) wait in the command queue while the back end works.
// Reset clears the batch state, both queues and the atlas size registers (to one).
// A full result queue stalls the back end only; the front end keeps taking items until
// the command queue fills.
module sprite_quad_batcher #(
  parameter int unsigned MAX_VERTS = sqb_pkg::MaxVertsDefault,
  parameter int unsigned CMD_DEPTH = sqb_pkg::CmdDepthDefault,
  parameter int unsigned RES_DEPTH = sqb_pkg::ResDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               operation_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic        [31:0] size_w_i,
  input  wire logic        [31:0] size_h_i,
  input  wire logic        [15:0] angle_i,
  input  wire logic        [31:0] src_origin_i,
  input  wire logic        [31:0] src_extent_i,
  input  wire logic        [15:0] texture_id_i,
  input  wire logic        [31:0] color_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    kind_o,
  output logic signed      [31:0] vert_x_o,
  output logic signed      [31:0] vert_y_o,
  output logic signed      [31:0] vert_z_o,
  output logic             [16:0] tex_u_o,
  output logic             [16:0] tex_v_o,
  output logic             [31:0] vert_color_o,
  output logic             [15:0] batch_texture_o,
  output logic             [12:0] index_count_o,
  output logic                    last_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic        [15:0] cfg_data_i
);

  import sqb_pkg::*;

  // Atlas size registers; the user must write them only while the block is idle, the block does not enforce it.
  logic [15:0] atlas_w_q, atlas_h_q;

  // Front end to command queue, command queue to back end.
  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;

  // Back end to result queue.
  res_t res_in, res_out;
  logic res_push, res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= 16'd1;
      atlas_h_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ATLAS_W: atlas_w_q <= cfg_data_i;
        default:     atlas_h_q <= cfg_data_i;
      endcase
    end
  end

  // The front end is full exactly when the command queue is.
  assign full = cmd_full;

  sqb_front #(
    .MAX_VERTS (MAX_VERTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .operation_i  (operation_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .size_w_i     (size_w_i),
    .size_h_i     (size_h_i),
    .angle_i      (angle_i),
    .src_origin_i (src_origin_i),
    .src_extent_i (src_extent_i),
    .texture_id_i (texture_id_i),
    .color_i      (color_i),
    .cmd_full_i   (cmd_full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  sqb_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  sqb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .atlas_w_i   (atlas_w_q),
    .atlas_h_i   (atlas_h_q),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  sqb_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .pop_i   (pop),
    .data_o  (res_out),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign kind_o          = res_out.kind;
  assign vert_x_o        = res_out.vert_x;
  assign vert_y_o        = res_out.vert_y;
  assign vert_z_o        = res_out.vert_z;
  assign tex_u_o         = res_out.tex_u;
  assign tex_v_o         = res_out.tex_v;
  assign vert_color_o    = res_out.vert_color;
  assign batch_texture_o = res_out.batch_texture;
  assign index_count_o   = res_out.index_count;
  assign last_o          = res_out.last;

endmodule

`default_nettype wire

// ----- rtl/core/sqb_fifo.sv -----
`default_nettype none

module sqb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sqb_front.sv -----
`default_nettype none

module sqb_front #(
  parameter int unsigned MAX_VERTS = sqb_pkg::MaxVertsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire logic               operation_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic signed [31:0] pos_z_i,
  input  wire logic        [31:0] size_w_i,
  input  wire logic        [31:0] size_h_i,
  input  wire logic        [15:0] angle_i,
  input  wire logic        [31:0] src_origin_i,
  input  wire logic        [31:0] src_extent_i,
  input  wire logic        [15:0] texture_id_i,
  input  wire logic        [31:0] color_i,
  input  wire logic               cmd_full_i,
  output logic                    cmd_push_o,
  output sqb_pkg::cmd_t           cmd_o
);

  import sqb_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTS + 1);
  localparam int unsigned BW = VW + 1;

  logic [15:0]    cur_tex_q, cur_tex_d;
  logic [VW-1:0]  vcnt_q, vcnt_d;
  logic [BW-1:0]  bic_q, bic_d;
  logic [BW+12:0] bic_ext;
  logic           accept, is_draw, do_flush, over;

  assign accept  = push_i && !cmd_full_i;
  assign is_draw = (operation_i == OP_DRAW);
  assign over    = ({1'b0, vcnt_q} + (VW + 1)'(4)) > (VW + 1)'(MAX_VERTS);
  // A draw closes the batch on a texture change or when four more vertices do not fit.
  assign do_flush = (bic_q != '0) && (!is_draw || (texture_id_i != cur_tex_q) || over);
  assign bic_ext  = {13'b0, bic_q};

  always_comb begin
    cmd_o.flush      = do_flush;
    cmd_o.flush_tex  = cur_tex_q;
    cmd_o.flush_cnt  = bic_ext[12:0];
    cmd_o.draw       = is_draw;
    cmd_o.pos_x      = pos_x_i;
    cmd_o.pos_y      = pos_y_i;
    cmd_o.pos_z      = pos_z_i;
    cmd_o.size_w     = size_w_i;
    cmd_o.size_h     = size_h_i;
    cmd_o.angle      = angle_i;
    cmd_o.src_origin = src_origin_i;
    cmd_o.src_extent = src_extent_i;
    cmd_o.color      = color_i;
    cmd_push_o       = accept && (is_draw || do_flush);

    cur_tex_d = cur_tex_q;
    vcnt_d    = vcnt_q;
    bic_d     = bic_q;
    if (accept) begin
      if (is_draw) begin
        cur_tex_d = texture_id_i;
        vcnt_d    = (do_flush ? '0 : vcnt_q) + VW'(4);
        bic_d     = (do_flush ? '0 : bic_q) + BW'(6);
      end else if (do_flush) begin
        cur_tex_d = '0;
        vcnt_d    = '0;
        bic_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_tex_q <= '0;
      vcnt_q    <= '0;
      bic_q     <= '0;
    end else begin
      cur_tex_q <= cur_tex_d;
      vcnt_q    <= vcnt_d;
      bic_q     <= bic_d;
    end
  end

`ifndef ASSERT_OFF
  a_vcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= VW'(MAX_VERTS))
    else $error("vertex count above limit");
  a_draw_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_draw) |=> (bic_q != '0) && (vcnt_q != '0))
    else $error("draw left no open batch");
  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_draw) |=> (bic_q == '0) && (cur_tex_q == '0))
    else $error("end left a batch open");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/sqb_cordic.sv -----
`default_nettype none

module sqb_cordic (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic        [15:0] angle_i,
  output logic                    done_o,
  output logic signed      [18:0] cos_o,
  output logic signed      [18:0] sin_o
);

  import sqb_pkg::*;

  logic signed [32:0] x_q, y_q, dx, dy, xr, yr;
  logic signed [16:0] z_q, at;
  logic        [1:0]  quad_q;
  logic        [4:0]  cnt_q;
  logic               busy_q, done_q;
  logic signed [18:0] cr, sr;

  assign dx = y_q >>> cnt_q[3:0];
  assign dy = x_q >>> cnt_q[3:0];
  assign at = $signed({3'b0, atan_lut(cnt_q[3:0])});
  assign xr = x_q + 33'sd8192;
  assign yr = y_q + 33'sd8192;
  assign cr = xr[32:14];
  assign sr = yr[32:14];
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q[4]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CordicK;
      y_q    <= '0;
      z_q    <= $signed({3'b0, angle_i[13:0]});
      quad_q <= angle_i[15:14];
    end else if (busy_q && !cnt_q[4]) begin
      if (!z_q[16]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end else if (busy_q) begin
      // Round to Q16 and fold back into the full circle.
      unique case (quad_q)
        2'd0: begin cos_o <= cr;  sin_o <= sr;  end
        2'd1: begin cos_o <= -sr; sin_o <= cr;  end
        2'd2: begin cos_o <= -cr; sin_o <= -sr; end
        default: begin cos_o <= sr; sin_o <= -cr; end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sqb_uv_div.sv -----
`default_nettype none

module sqb_uv_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [16:0] num_i,
  input  wire logic [15:0] den_i,
  output logic             done_o,
  output logic      [16:0] quot_o
);

  logic [15:0] den_eff, den_q, rem_q;
  logic [16:0] bits_q, quo_q, trial, diff;
  logic [4:0]  cnt_q;
  logic        sat_q, busy_q, done_q, ge;

  // Numerator is num * 65536 + den / 2; a zero divisor acts as one.
  assign den_eff = (den_i == '0) ? 16'd1 : den_i;
  assign trial   = {rem_q, bits_q[16]};
  assign ge      = trial >= {1'b0, den_q};
  assign diff    = trial - {1'b0, den_q};
  assign done_o  = done_q;
  assign quot_o  = (sat_q || (quo_q > 17'd65536)) ? 17'd65536 : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd16) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_eff;
      rem_q  <= num_i[16:1];
      sat_q  <= num_i[16:1] >= den_eff;
      bits_q <= {num_i[0], 1'b0, den_eff[15:1]};
      quo_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[15:0] : trial[15:0];
      quo_q  <= {quo_q[15:0], ge};
      bits_q <= {bits_q[15:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sqb_back.sv -----
`default_nettype none

module sqb_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic   [15:0] atlas_w_i,
  input  wire logic   [15:0] atlas_h_i,
  input  wire logic          cmd_empty_i,
  input  sqb_pkg::cmd_t      cmd_i,
  output logic               cmd_pop_o,
  input  wire logic          res_full_i,
  output logic               res_push_o,
  output sqb_pkg::res_t      res_o
);

  import sqb_pkg::*;

  back_state_e        state_q, state_d;
  cmd_t               cmd_q;
  logic        [1:0]  corner_q;
  logic               start, cordic_done;
  logic signed [18:0] cos_v, sin_v;
  logic        [3:0]  div_done;
  logic        [16:0] q_umin, q_umax, q_vlo, q_vhi;
  logic        [16:0] num_umax, num_vlo, tex_u, tex_v;
  logic signed [32:0] w_s, h_s;
  logic signed [51:0] p_wc, p_hs, p_ws, p_hc;
  logic signed [51:0] wc_q, hs_q, ws_q, hc_q;
  logic signed [52:0] wc_e, hs_e, ws_e, hc_e, ta, tb, tc, td;
  logic signed [53:0] rx_sum, ry_sum;
  logic signed [36:0] rx_q, ry_q;
  logic signed [37:0] x_sum, y_sum;
  logic               sx_neg, sy_neg;

  assign start = (state_q == BK_START);

  sqb_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .angle_i (cmd_q.angle),
    .done_o  (cordic_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  assign num_umax = {1'b0, cmd_q.src_origin[15:0]} + {1'b0, cmd_q.src_extent[15:0]};
  assign num_vlo  = {1'b0, cmd_q.src_origin[31:16]} + {1'b0, cmd_q.src_extent[31:16]};

  sqb_uv_div u_div_umin (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start),
    .num_i ({1'b0, cmd_q.src_origin[15:0]}), .den_i (atlas_w_i),
    .done_o (div_done[0]), .quot_o (q_umin)
  );
  sqb_uv_div u_div_umax (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start),
    .num_i (num_umax), .den_i (atlas_w_i),
    .done_o (div_done[1]), .quot_o (q_umax)
  );
  sqb_uv_div u_div_vlo (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start),
    .num_i (num_vlo), .den_i (atlas_h_i),
    .done_o (div_done[2]), .quot_o (q_vlo)
  );
  sqb_uv_div u_div_vhi (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start),
    .num_i ({1'b0, cmd_q.src_origin[31:16]}), .den_i (atlas_h_i),
    .done_o (div_done[3]), .quot_o (q_vhi)
  );

  // Full-size products; the corner signs and the halving by the final shift are applied afterwards.
  assign w_s  = $signed({1'b0, cmd_q.size_w});
  assign h_s  = $signed({1'b0, cmd_q.size_h});
  assign p_wc = w_s * cos_v;
  assign p_hs = h_s * sin_v;
  assign p_ws = w_s * sin_v;
  assign p_hc = h_s * cos_v;

  assign sx_neg = (corner_q == 2'd0) || (corner_q == 2'd3);
  assign sy_neg = corner_q[1];
  assign wc_e   = wc_q;
  assign hs_e   = hs_q;
  assign ws_e   = ws_q;
  assign hc_e   = hc_q;
  assign ta     = sx_neg ? -wc_e : wc_e;
  assign tb     = sy_neg ? -hs_e : hs_e;
  assign tc     = sx_neg ? -ws_e : ws_e;
  assign td     = sy_neg ? -hc_e : hc_e;
  assign rx_sum = ta - tb + 54'sd65536;
  assign ry_sum = tc + td + 54'sd65536;
  assign x_sum  = $signed(cmd_q.pos_x) + rx_q;
  assign y_sum  = $signed(cmd_q.pos_y) + ry_q;

  // Left corners take umin, top corners take the flipped far edge.
  assign tex_u = (corner_q == 2'd0 || corner_q == 2'd3) ? q_umin : q_umax;
  assign tex_v = corner_q[1] ? (17'd65536 - q_vhi) : (17'd65536 - q_vlo);

  always_comb begin
    state_d    = state_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    unique case (state_q)
      BK_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          state_d   = cmd_i.flush ? BK_FLUSH : BK_START;
        end
      end
      BK_FLUSH: begin
        res_o.kind          = KIND_FLUSH;
        res_o.batch_texture = cmd_q.flush_tex;
        res_o.index_count   = cmd_q.flush_cnt;
        res_o.last          = !cmd_q.draw;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = cmd_q.draw ? BK_START : BK_IDLE;
        end
      end
      BK_START: state_d = BK_CALC;
      BK_CALC: begin
        if (cordic_done && (&div_done)) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL:   state_d = BK_COR_A;
      BK_COR_A: state_d = BK_COR_B;
      BK_COR_B: begin
        res_o.kind       = KIND_VERTEX;
        res_o.vert_x     = sat32(x_sum);
        res_o.vert_y     = sat32(y_sum);
        res_o.vert_z     = cmd_q.pos_z;
        res_o.tex_u      = tex_u;
        res_o.tex_v      = tex_v;
        res_o.vert_color = cmd_q.color;
        res_o.last       = (corner_q == 2'd3);
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = (corner_q == 2'd3) ? BK_IDLE : BK_COR_A;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      corner_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_MUL) begin
        corner_q <= '0;
      end else if (res_push_o && (state_q == BK_COR_B)) begin
        corner_q <= corner_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    if (state_q == BK_MUL) begin
      wc_q <= p_wc;
      hs_q <= p_hs;
      ws_q <= p_ws;
      hc_q <= p_hc;
    end
    if (state_q == BK_COR_A) begin
      rx_q <= rx_sum[53:17];
      ry_q <= ry_sum[53:17];
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result word pushed into a full queue");
  a_units_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_MUL) |-> cordic_done && (&div_done))
    else $error("products taken before the angle and divide units finished");
  a_quad_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && (state_q == BK_COR_B) && (corner_q == 2'd3)) |=> (state_q == BK_IDLE))
    else $error("sequencer did not return to idle after the fourth corner");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_sprite_quad_batcher.sv -----
`timescale 1ns / 1ps

// Checks the sprite quad batcher against a predictor of its own. Draw and end
// items go in through the queue-style input; every vertex and flush word that
// comes out is compared field by field with the oldest predicted word.
module tb_sprite_quad_batcher;
  import sqb_pkg::*;

  localparam int unsigned MaxVerts = 4096;
  localparam int unsigned StallLimit = 20000;

  // One input item as the block sees it.
  typedef struct {
    logic        op;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] sw;
    logic [31:0] sh;
    logic [15:0] ang;
    logic [31:0] org;
    logic [31:0] ext;
    logic [15:0] tex;
    logic [31:0] col;
  } sprite_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        operation_i = OP_DRAW;
  logic [31:0] pos_x_i = '0;
  logic [31:0] pos_y_i = '0;
  logic [31:0] pos_z_i = '0;
  logic [31:0] size_w_i = '0;
  logic [31:0] size_h_i = '0;
  logic [15:0] angle_i = '0;
  logic [31:0] src_origin_i = '0;
  logic [31:0] src_extent_i = '0;
  logic [15:0] texture_id_i = '0;
  logic [31:0] color_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind_o;
  logic [31:0] vert_x_o;
  logic [31:0] vert_y_o;
  logic [31:0] vert_z_o;
  logic [16:0] tex_u_o;
  logic [16:0] tex_v_o;
  logic [31:0] vert_color_o;
  logic [15:0] batch_texture_o;
  logic [12:0] index_count_o;
  logic        last_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CFG_ATLAS_W;
  logic [15:0] cfg_data_i = '0;

  always #4 clk_i = ~clk_i;

  sprite_quad_batcher uut (
    .clk_i, .rst_ni, .push, .full, .operation_i, .pos_x_i, .pos_y_i, .pos_z_i,
    .size_w_i, .size_h_i, .angle_i, .src_origin_i, .src_extent_i, .texture_id_i,
    .color_i, .empty, .pop, .kind_o, .vert_x_o, .vert_y_o, .vert_z_o, .tex_u_o,
    .tex_v_o, .vert_color_o, .batch_texture_o, .index_count_o, .last_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Predictor state: atlas size and the open batch.
  logic [15:0] atlas_w_q = 16'd1;
  logic [15:0] atlas_h_q = 16'd1;
  logic [15:0] batch_tex_q = '0;
  int unsigned batch_verts_q = 0;
  int unsigned batch_idx_q = 0;

  res_t   pending_words[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     quiet_cycles = 0;

  // Arithmetic shift right that rounds toward minus infinity.
  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Texel to Q1.16 coordinate, rounded half up and limited to 1.0.
  function automatic longint texel_to_q16(longint num, logic [15:0] div);
    longint d;
    longint q;
    d = (div == 0) ? 1 : longint'(div);
    q = (num * 65536 + d / 2) / d;
    return (q > 65536) ? 65536 : q;
  endfunction

  // CORDIC sine and cosine in Q16, mirrored into the angle's quadrant.
  task automatic rotation_q16(input logic [15:0] ang, output longint c, output longint s);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint cr;
    longint sr;
    x = 652032875;
    y = 0;
    z = longint'(ang[13:0]);
    for (int i = 0; i < 16; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_lut(4'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_lut(4'(i)));
      end
    end
    cr = shr_floor(x + 8192, 14);
    sr = shr_floor(y + 8192, 14);
    case (ang[15:14])
      2'd0: begin c = cr; s = sr; end
      2'd1: begin c = -sr; s = cr; end
      2'd2: begin c = -cr; s = -sr; end
      default: begin c = sr; s = -cr; end
    endcase
  endtask

  function automatic void close_batch();
    res_t r;
    if (batch_idx_q == 0) return;
    r = '0;
    r.kind = KIND_FLUSH;
    r.batch_texture = batch_tex_q;
    r.index_count = batch_idx_q[12:0];
    pending_words.push_back(r);
    batch_verts_q = 0;
    batch_idx_q = 0;
    batch_tex_q = '0;
  endfunction

  // Works out every word that one accepted item should produce.
  task automatic predict_quad_words(input sprite_item_t it);
    longint c;
    longint s;
    longint w;
    longint h;
    longint cx;
    longint cy;
    longint umin;
    longint umax;
    longint vmin;
    longint vmax;
    int unsigned n0;
    res_t r;
    n0 = pending_words.size();
    if (it.op == OP_END) begin
      close_batch();
      if (pending_words.size() > n0) pending_words[$].last = 1'b1;
      return;
    end
    if (it.tex != batch_tex_q && batch_idx_q > 0) close_batch();
    if (batch_verts_q + 4 > MaxVerts) close_batch();
    batch_tex_q = it.tex;
    rotation_q16(it.ang, c, s);
    w = longint'(it.sw);
    h = longint'(it.sh);
    umin = texel_to_q16(longint'(it.org[15:0]), atlas_w_q);
    umax = texel_to_q16(longint'(it.org[15:0]) + longint'(it.ext[15:0]), atlas_w_q);
    vmin = 65536 - texel_to_q16(longint'(it.org[31:16]) + longint'(it.ext[31:16]), atlas_h_q);
    vmax = 65536 - texel_to_q16(longint'(it.org[31:16]), atlas_h_q);
    for (int i = 0; i < 4; i++) begin
      cx = (i == 0 || i == 3) ? -w : w;
      cy = (i < 2) ? h : -h;
      r = '0;
      r.kind = KIND_VERTEX;
      r.vert_x = clamp32(longint'($signed(it.px)) + shr_floor(cx * c - cy * s + 65536, 17));
      r.vert_y = clamp32(longint'($signed(it.py)) + shr_floor(cx * s + cy * c + 65536, 17));
      r.vert_z = it.pz;
      r.tex_u = (i == 0 || i == 3) ? umin[16:0] : umax[16:0];
      r.tex_v = (i < 2) ? vmin[16:0] : vmax[16:0];
      r.vert_color = it.col;
      r.last = (i == 3);
      pending_words.push_back(r);
    end
    batch_verts_q += 4;
    batch_idx_q += 6;
  endtask

  // Sends one item and predicts its words once it is accepted. The request stays
  // up afterwards so that a following item can go in on the next cycle.
  task automatic send_item(input sprite_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    operation_i <= it.op;
    pos_x_i <= it.px;
    pos_y_i <= it.py;
    pos_z_i <= it.pz;
    size_w_i <= it.sw;
    size_h_i <= it.sh;
    angle_i <= it.ang;
    src_origin_i <= it.org;
    src_extent_i <= it.ext;
    texture_id_i <= it.tex;
    color_i <= it.col;
    do @(posedge clk_i); while (full);
    predict_quad_words(it);
    @(negedge clk_i);
  endtask

  // Drops the request, waits until every predicted word has come, then lets the
  // back end settle.
  task automatic drain_words();
    push <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_atlas(input logic idx, input logic [15:0] val);
    drain_words();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ATLAS_W) atlas_w_q = val;
    else atlas_h_q = val;
  endtask

  function automatic sprite_item_t random_sprite(int unsigned tex_span);
    sprite_item_t it;
    it.op = OP_DRAW;
    it.px = $urandom();
    it.py = $urandom();
    it.pz = $urandom();
    it.sw = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0080_0000);
    it.sh = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(32'h0080_0000);
    it.ang = 16'($urandom());
    it.org = $urandom();
    it.ext = $urandom();
    it.tex = (tex_span == 0) ? 16'($urandom()) : 16'($urandom_range(tex_span));
    it.col = $urandom();
    return it;
  endfunction

  function automatic sprite_item_t end_item();
    sprite_item_t it;
    it = random_sprite(0);
    it.op = OP_END;
    return it;
  endfunction

  // Result side: random pops, compare against the oldest prediction.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0b x=%h", $time, kind_o, vert_x_o);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if ({kind_o, vert_x_o, vert_y_o, vert_z_o, tex_u_o, tex_v_o, vert_color_o,
             batch_texture_o, index_count_o, last_o} !== want) begin
          $display("%0t: word mismatch expected %h actual %h", $time, want,
                   {kind_o, vert_x_o, vert_y_o, vert_z_o, tex_u_o, tex_v_o,
                    vert_color_o, batch_texture_o, index_count_o, last_o});
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) pop <= ($urandom_range(99) >= recv_idle_pct);

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || !rst_ni) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Field extremes, all rotation quadrants and both operations.
  task automatic test_directed_extremes();
    sprite_item_t it;
    send_item(end_item());  // nothing open: no word
    it = random_sprite(0);
    it.px = 32'h7fff_ffff; it.py = 32'h8000_0000; it.sw = '1; it.sh = '1;
    it.ang = 16'h0000; it.org = '0; it.ext = '1; it.tex = 16'h0000;
    send_item(it);  // texture zero, saturated corners, full UV range
    for (int q = 0; q < 4; q++) begin
      it = random_sprite(0);
      it.ang = 16'(q * 16384 + (q == 3 ? 16383 : 0));
      it.tex = 16'h0000;
      it.org = 32'hffff_ffff;
      send_item(it);
    end
    it.tex = 16'hffff; it.ext = '0; it.sw = '0; it.sh = '0; it.px = '0; it.py = '0;
    send_item(it);  // texture change closes the batch
    send_item(end_item());
    send_item(end_item());
  endtask

  // Atlas registers at their extremes, zero acting as one.
  task automatic test_atlas_settings();
    logic [15:0] sizes[5] = '{16'd0, 16'd1, 16'd65535, 16'd256, 16'd37};
    sprite_item_t it;
    foreach (sizes[i]) begin
      write_atlas(CFG_ATLAS_W, sizes[i]);
      write_atlas(CFG_ATLAS_H, sizes[4 - i]);
      repeat (4) begin
        it = random_sprite(3);
        if ($urandom_range(1)) it.org = $urandom_range(32'h0100_0100);
        send_item(it);
      end
      send_item(end_item());
    end
  endtask

  // Runs of sprites with a few textures, some end items, under one idle mix.
  task automatic test_random_frames(int unsigned count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(19) == 0) send_item(end_item());
      else send_item(random_sprite($urandom_range(3) == 0 ? 0 : 2));
      if (n == count / 2) drain_words();  // sender holds off until all words are out
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_extremes();
    test_atlas_settings();
    send_idle_pct = 6; recv_idle_pct = 76;
    test_random_frames(110);
    send_idle_pct = 76; recv_idle_pct = 6;
    test_random_frames(110);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_frames(110);
    drain_words();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/sqb_pkg.sv
rtl/core/sqb_fifo.sv
rtl/core/sqb_front.sv
rtl/core/sqb_cordic.sv
rtl/core/sqb_uv_div.sv
rtl/core/sqb_back.sv
rtl/core/sprite_quad_batcher.sv
sim/tb_sprite_quad_batcher.sv
